// ===== src/glyph_text_layout_unit_macros.svh =====
//------------------------------------------------------------------------------
// Glyph text layout unit: assertion macros
// Property macros for the concurrent checks of the top-level unit.
//------------------------------------------------------------------------------
`ifndef GLYPH_TEXT_LAYOUT_UNIT_MACROS_SVH
`define GLYPH_TEXT_LAYOUT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define GLU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph layout check failed");

// The consequent must hold in the cycle after the antecedent.
`define GLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph layout check failed");

`else

`define GLU_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define GLU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/glu_pkg.sv =====
//------------------------------------------------------------------------------
// Glyph text layout unit package
// Widths, character codes, register indexes and the control interface types.
//------------------------------------------------------------------------------
package glu_pkg;

   // Glyph table geometry.
   localparam int GLYPH_COUNT = 128;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

   // Field widths.
   localparam int CODE_W   = 7;
   localparam int ATLAS_W  = 12;
   localparam int OFS_W    = 10;
   localparam int ADV_W    = 10;
   localparam int POS_W    = 16;
   localparam int FONT_W   = 8;
   localparam int COLOR_W  = 32;
   localparam int SIZE_W   = 15;
   localparam int CURSOR_W = 15;

   // Scaling arithmetic widths.
   localparam int OPER_W        = ATLAS_W;
   localparam int MUL_W         = OPER_W + FONT_W;
   localparam int QUO_W         = MUL_W;
   localparam int DIVISOR_W     = ADV_W + 1;
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = QUO_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
   localparam int SUM_W         = QUO_W + 3;

   // Saturation limits.
   localparam int DST_MAX = 32767;
   localparam int DST_MIN = -32768;
   localparam logic [SIZE_W-1:0]   SIZE_MAX   = '1;
   localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;

   // Character codes with special handling.
   localparam logic [CODE_W-1:0] CH_NEWLINE    = 7'd10;
   localparam logic [CODE_W-1:0] CH_SPACE      = 7'd32;
   localparam logic [CODE_W-1:0] CH_UNDERSCORE = 7'd95;

   // Request functions.
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_RENDER = 1'b1;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR     = 3'd3;
   localparam logic [FONT_W-1:0]    FONT_SIZE_RESET = 8'd16;

   // One glyph table entry.
   typedef struct packed {
      logic [ATLAS_W-1:0]       ax;
      logic [ATLAS_W-1:0]       ay;
      logic [ATLAS_W-1:0]       w;
      logic [ATLAS_W-1:0]       h;
      logic signed [OFS_W-1:0]  ox;
      logic signed [OFS_W-1:0]  oy;
      logic [ADV_W-1:0]         adv;
   } glyph_entry_type;

   // Values scaled in turn through the shared divider.
   typedef enum logic [2:0] {
      TERM_OFS_X,
      TERM_OFS_Y,
      TERM_WIDTH,
      TERM_HEIGHT,
      TERM_ADVANCE
   } term_type;

   localparam int NUM_TERMS = 5;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     glyph_write;
      logic     newline;
      logic     char_start;
      logic     mul_load;
      logic     div_start;
      logic     quo_store;
      logic     emit;
      term_type term;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_write;
      logic req_is_newline;
      logic div_busy;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== src/glu_divider.sv =====
//------------------------------------------------------------------------------
// Glyph text layout unit: iterative divider
// Unsigned restoring divider that retires several quotient bits per cycle.
//------------------------------------------------------------------------------
module glu_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [glu_pkg::QUO_W-1:0]       dividend,
   input  logic [glu_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            busy,
   output logic                            done,
   output logic [glu_pkg::QUO_W-1:0]       quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [glu_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [glu_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [glu_pkg::QUO_W-1:0]       work_ff, work_in;
   logic [glu_pkg::DIVISOR_W-1:0]   divisor_ff, divisor_in;

   logic [glu_pkg::DIVISOR_W-1:0]   rem_v;
   logic [glu_pkg::QUO_W-1:0]       work_v;
   logic [glu_pkg::DIVISOR_W:0]     trial_v;

   // A few restoring steps per cycle: shift in a dividend bit, subtract if it fits.
   always_comb begin
      rem_v  = rem_ff;
      work_v = work_ff;
      trial_v = '0;
      for (int i = 0; i < glu_pkg::DIV_STEP_BITS; i++) begin
         trial_v = {rem_v, work_v[glu_pkg::QUO_W-1]};
         work_v  = {work_v[glu_pkg::QUO_W-2:0], 1'b0};
         if (trial_v >= {1'b0, divisor_ff}) begin
            rem_v     = glu_pkg::DIVISOR_W'(trial_v - {1'b0, divisor_ff});
            work_v[0] = 1'b1;
         end else begin
            rem_v = glu_pkg::DIVISOR_W'(trial_v);
         end
      end
   end

   // Next state of the iteration.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         work_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = rem_v;
         work_in = work_v;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == glu_pkg::DIV_CNT_W'(glu_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// ===== src/glu_datapath.sv =====
//------------------------------------------------------------------------------
// Glyph text layout unit: datapath
// Glyph table, configuration and cursor registers, scaling and quad output.
//------------------------------------------------------------------------------
module glu_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  glu_pkg::dp_cmd_type                    cmd,
   output glu_pkg::dp_status_type                 status,
   input  logic                                   req_func,
   input  logic [glu_pkg::CODE_W-1:0]             req_char_code,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_atlas_x,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_atlas_y,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_glyph_w,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_glyph_h,
   input  logic signed [glu_pkg::OFS_W-1:0]       req_offset_x,
   input  logic signed [glu_pkg::OFS_W-1:0]       req_offset_y,
   input  logic [glu_pkg::ADV_W-1:0]              req_advance,
   input  logic                                   req_end_of_text,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [glu_pkg::POS_W-1:0]       rsp_dst_x,
   output logic signed [glu_pkg::POS_W-1:0]       rsp_dst_y,
   output logic [glu_pkg::SIZE_W-1:0]             rsp_dst_w,
   output logic [glu_pkg::SIZE_W-1:0]             rsp_dst_h,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_x,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_y,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_w,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_h,
   output logic [glu_pkg::COLOR_W-1:0]            rsp_quad_color,
   output logic                                   rsp_last,
   input  logic                                   csr_wr_en,
   input  logic [glu_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [glu_pkg::CSR_DATA_W-1:0]         csr_wr_data
);

   // Glyph table memory with one valid bit per entry.
   glu_pkg::glyph_entry_type                 glyph_mem [glu_pkg::GLYPH_COUNT];
   logic [glu_pkg::GLYPH_COUNT-1:0]          valid_ff;
   glu_pkg::glyph_entry_type                 rd_ff;
   glu_pkg::glyph_entry_type                 wr_entry;
   logic [glu_pkg::GLYPH_IDX_W-1:0]          req_idx;

   // Configuration and state registers.
   logic signed [glu_pkg::POS_W-1:0]         pos_x_ff;
   logic signed [glu_pkg::POS_W-1:0]         pos_y_ff;
   logic [glu_pkg::FONT_W-1:0]               font_size_ff;
   logic [glu_pkg::COLOR_W-1:0]              color_ff;
   logic [glu_pkg::ADV_W-1:0]                uscore_adv_ff;
   logic [glu_pkg::CURSOR_W-1:0]             cursor_x_ff, cursor_x_in;
   logic [glu_pkg::CURSOR_W-1:0]             cursor_y_ff, cursor_y_in;

   // Per-character working registers.
   logic [glu_pkg::CODE_W-1:0]               code_ff;
   logic                                     eot_ff;
   logic [glu_pkg::MUL_W-1:0]                product_ff;
   logic                                     neg_ff;
   logic [glu_pkg::QUO_W-1:0]                q_ff [glu_pkg::NUM_TERMS];
   logic [glu_pkg::NUM_TERMS-1:0]            q_neg_ff;

   // Output register.
   logic                                     rsp_valid_ff;
   logic signed [glu_pkg::POS_W-1:0]         dst_x_ff, dst_x_in;
   logic signed [glu_pkg::POS_W-1:0]         dst_y_ff, dst_y_in;
   logic [glu_pkg::SIZE_W-1:0]               dst_w_ff, dst_w_in;
   logic [glu_pkg::SIZE_W-1:0]               dst_h_ff, dst_h_in;
   logic [glu_pkg::ATLAS_W-1:0]              src_x_ff, src_y_ff, src_w_ff, src_h_ff;
   logic [glu_pkg::COLOR_W-1:0]              color_out_ff;
   logic                                     last_ff;

   // Combinational helpers.
   logic [glu_pkg::OPER_W-1:0]               oper_v;
   logic                                     oper_neg_v;
   logic [glu_pkg::OPER_W-1:0]               ofs_ext_v;
   logic [glu_pkg::DIVISOR_W-1:0]            line_height;
   logic                                     lh_zero;
   logic                                     div_busy, div_done;
   logic [glu_pkg::QUO_W-1:0]                div_quo;
   logic signed [glu_pkg::SUM_W-1:0]         sx_v, sy_v, sum_x_v, sum_y_v;
   logic [glu_pkg::QUO_W:0]                  cx_sum_v;
   logic [glu_pkg::CURSOR_W:0]               cy_sum_v;

   assign req_idx  = glu_pkg::GLYPH_IDX_W'(req_char_code);
   assign wr_entry = '{ax: req_atlas_x, ay: req_atlas_y, w: req_glyph_w, h: req_glyph_h,
                       ox: req_offset_x, oy: req_offset_y, adv: req_advance};

   // Line height is twice the underscore advance.
   assign line_height = {uscore_adv_ff, 1'b0};
   assign lh_zero     = (uscore_adv_ff == '0);

   // Request classification for the controller.
   assign status.req_is_write   = (req_func == glu_pkg::FUNC_WRITE);
   assign status.req_is_newline = (req_char_code == glu_pkg::CH_NEWLINE);
   assign status.div_busy       = div_busy;
   assign status.div_done       = div_done;
   assign status.rsp_free       = !rsp_valid_ff || rsp_ready;

   // Glyph memory write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.glyph_write) begin
         glyph_mem[req_idx] <= wr_entry;
      end
      if (cmd.char_start) begin
         rd_ff <= valid_ff[req_idx] ? glyph_mem[req_idx] : '0;
      end
   end

   // Valid bits and the underscore advance copy, both cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         uscore_adv_ff <= '0;
      end else if (cmd.glyph_write) begin
         valid_ff[req_idx] <= 1'b1;
         if (req_char_code == glu_pkg::CH_UNDERSCORE) begin
            uscore_adv_ff <= req_advance;
         end
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         font_size_ff <= glu_pkg::FONT_SIZE_RESET;
         color_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            glu_pkg::CSR_POS_X:     pos_x_ff     <= csr_wr_data[glu_pkg::POS_W-1:0];
            glu_pkg::CSR_POS_Y:     pos_y_ff     <= csr_wr_data[glu_pkg::POS_W-1:0];
            glu_pkg::CSR_FONT_SIZE: font_size_ff <= csr_wr_data[glu_pkg::FONT_W-1:0];
            glu_pkg::CSR_COLOR:     color_ff     <= csr_wr_data[glu_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the value being scaled: magnitude and sign.
   always_comb begin
      oper_v     = '0;
      oper_neg_v = 1'b0;
      ofs_ext_v  = '0;
      case (cmd.term)
         glu_pkg::TERM_OFS_X: begin
            ofs_ext_v  = glu_pkg::OPER_W'(rd_ff.ox);
            oper_neg_v = rd_ff.ox[glu_pkg::OFS_W-1];
            oper_v     = oper_neg_v ? (~ofs_ext_v + 1'b1) : ofs_ext_v;
         end
         glu_pkg::TERM_OFS_Y: begin
            ofs_ext_v  = glu_pkg::OPER_W'(rd_ff.oy);
            oper_neg_v = rd_ff.oy[glu_pkg::OFS_W-1];
            oper_v     = oper_neg_v ? (~ofs_ext_v + 1'b1) : ofs_ext_v;
         end
         glu_pkg::TERM_WIDTH:  oper_v = rd_ff.w;
         glu_pkg::TERM_HEIGHT: oper_v = rd_ff.h;
         glu_pkg::TERM_ADVANCE: begin
            // A space advances by the underscore advance.
            oper_v = (code_ff == glu_pkg::CH_SPACE) ? glu_pkg::OPER_W'(uscore_adv_ff)
                                                    : glu_pkg::OPER_W'(rd_ff.adv);
         end
         default: ;
      endcase
   end

   // Multiply by the font size, then divide by the line height.
   always_ff @(posedge clock) begin
      if (cmd.char_start) begin
         code_ff <= req_char_code;
         eot_ff  <= req_end_of_text;
      end
      if (cmd.mul_load) begin
         product_ff <= glu_pkg::MUL_W'(oper_v) * glu_pkg::MUL_W'(font_size_ff);
         neg_ff     <= oper_neg_v;
      end
      if (cmd.quo_store) begin
         q_ff[cmd.term]     <= lh_zero ? '0 : div_quo;
         q_neg_ff[cmd.term] <= neg_ff;
      end
   end

   glu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (product_ff),
      .divisor  (line_height),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Quad placement, size saturation and cursor update.
   always_comb begin
      sx_v = signed'(glu_pkg::SUM_W'(q_ff[glu_pkg::TERM_OFS_X]));
      sy_v = signed'(glu_pkg::SUM_W'(q_ff[glu_pkg::TERM_OFS_Y]));
      if (q_neg_ff[glu_pkg::TERM_OFS_X]) begin
         sx_v = -sx_v;
      end
      if (q_neg_ff[glu_pkg::TERM_OFS_Y]) begin
         sy_v = -sy_v;
      end
      sum_x_v = sx_v + signed'(glu_pkg::SUM_W'(cursor_x_ff)) + glu_pkg::SUM_W'(pos_x_ff);
      sum_y_v = sy_v + signed'(glu_pkg::SUM_W'(cursor_y_ff)) + glu_pkg::SUM_W'(pos_y_ff);

      if (sum_x_v > glu_pkg::DST_MAX) begin
         dst_x_in = glu_pkg::POS_W'(glu_pkg::DST_MAX);
      end else if (sum_x_v < glu_pkg::DST_MIN) begin
         dst_x_in = glu_pkg::POS_W'(glu_pkg::DST_MIN);
      end else begin
         dst_x_in = sum_x_v[glu_pkg::POS_W-1:0];
      end
      if (sum_y_v > glu_pkg::DST_MAX) begin
         dst_y_in = glu_pkg::POS_W'(glu_pkg::DST_MAX);
      end else if (sum_y_v < glu_pkg::DST_MIN) begin
         dst_y_in = glu_pkg::POS_W'(glu_pkg::DST_MIN);
      end else begin
         dst_y_in = sum_y_v[glu_pkg::POS_W-1:0];
      end

      dst_w_in = (q_ff[glu_pkg::TERM_WIDTH] > glu_pkg::QUO_W'(glu_pkg::SIZE_MAX))
               ? glu_pkg::SIZE_MAX : q_ff[glu_pkg::TERM_WIDTH][glu_pkg::SIZE_W-1:0];
      dst_h_in = (q_ff[glu_pkg::TERM_HEIGHT] > glu_pkg::QUO_W'(glu_pkg::SIZE_MAX))
               ? glu_pkg::SIZE_MAX : q_ff[glu_pkg::TERM_HEIGHT][glu_pkg::SIZE_W-1:0];

      cx_sum_v = (glu_pkg::QUO_W+1)'(cursor_x_ff) + (glu_pkg::QUO_W+1)'(q_ff[glu_pkg::TERM_ADVANCE]);
      cy_sum_v = {1'b0, cursor_y_ff} + (glu_pkg::CURSOR_W+1)'(font_size_ff);

      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (cmd.newline) begin
         // Newline returns to the left edge and steps down by the font size.
         cursor_x_in = '0;
         cursor_y_in = (cy_sum_v > (glu_pkg::CURSOR_W+1)'(glu_pkg::CURSOR_MAX))
                     ? glu_pkg::CURSOR_MAX : cy_sum_v[glu_pkg::CURSOR_W-1:0];
         if (req_end_of_text) begin
            cursor_x_in = '0;
            cursor_y_in = '0;
         end
      end else if (cmd.emit) begin
         cursor_x_in = (cx_sum_v > (glu_pkg::QUO_W+1)'(glu_pkg::CURSOR_MAX))
                     ? glu_pkg::CURSOR_MAX : cx_sum_v[glu_pkg::CURSOR_W-1:0];
         if (eot_ff) begin
            cursor_x_in = '0;
            cursor_y_in = '0;
         end
      end
   end

   // Cursor and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         dst_x_ff     <= dst_x_in;
         dst_y_ff     <= dst_y_in;
         dst_w_ff     <= dst_w_in;
         dst_h_ff     <= dst_h_in;
         src_x_ff     <= rd_ff.ax;
         src_y_ff     <= rd_ff.ay;
         src_w_ff     <= rd_ff.w;
         src_h_ff     <= rd_ff.h;
         color_out_ff <= color_ff;
         last_ff      <= eot_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dst_x      = dst_x_ff;
   assign rsp_dst_y      = dst_y_ff;
   assign rsp_dst_w      = dst_w_ff;
   assign rsp_dst_h      = dst_h_ff;
   assign rsp_src_x      = src_x_ff;
   assign rsp_src_y      = src_y_ff;
   assign rsp_src_w      = src_w_ff;
   assign rsp_src_h      = src_h_ff;
   assign rsp_quad_color = color_out_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== src/glu_controller.sv =====
//------------------------------------------------------------------------------
// Glyph text layout unit: controller
// Sequences table writes, newlines and the five scaling passes of a character.
//------------------------------------------------------------------------------
module glu_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  glu_pkg::dp_status_type   status,
   output glu_pkg::dp_cmd_type      cmd
);

   glu_pkg::state_type   state_ff, state_in;
   glu_pkg::term_type    term_ff, term_in;

   // State and pass counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glu_pkg::ST_IDLE;
         term_ff  <= glu_pkg::TERM_OFS_X;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      term_in   = term_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.term  = term_ff;
      unique case (state_ff)
         glu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.req_is_write) begin
                  cmd.glyph_write = 1'b1;
               end else if (status.req_is_newline) begin
                  cmd.newline = 1'b1;
               end else begin
                  cmd.char_start = 1'b1;
                  term_in        = glu_pkg::TERM_OFS_X;
                  state_in       = glu_pkg::ST_MUL;
               end
            end
         end
         glu_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = glu_pkg::ST_DIV_START;
         end
         glu_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = glu_pkg::ST_DIV_WAIT;
         end
         glu_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.quo_store = 1'b1;
               if (term_ff == glu_pkg::TERM_ADVANCE) begin
                  state_in = glu_pkg::ST_EMIT;
               end else begin
                  term_in  = glu_pkg::term_type'(term_ff + 1'b1);
                  state_in = glu_pkg::ST_MUL;
               end
            end
         end
         glu_pkg::ST_EMIT: begin
            // Hold the quad until the output register is free.
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = glu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = glu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/glyph_text_layout_unit.sv =====
//------------------------------------------------------------------------------
// Glyph text layout unit
// Turns a character stream into screen quads from a bitmap-font glyph table.
//------------------------------------------------------------------------------
// Glyph table writes and newline requests are carried out in the idle state,
// which stays ready for the next request. A drawn character leaves the idle
// state once accepted, and no new request is taken until its quad is loaded
// into the output register from the emit state. Five values (two offsets,
// width, height, advance) are scaled one after the other, each through a
// multiply state, a divider load state and a wait on the shared divider,
// which retires four quotient bits per cycle, ending in a store of the
// quotient. The next request is accepted while a finished quad waits in the
// output register; a quad that finds the register still full waits until it
// is taken. The glyph table valid bits clear in the reset cycle itself, so
// no clearing pass follows reset.
//------------------------------------------------------------------------------
`include "glyph_text_layout_unit_macros.svh"

module glyph_text_layout_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic [glu_pkg::CODE_W-1:0]             req_char_code,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_atlas_x,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_atlas_y,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_glyph_w,
   input  logic [glu_pkg::ATLAS_W-1:0]            req_glyph_h,
   input  logic signed [glu_pkg::OFS_W-1:0]       req_offset_x,
   input  logic signed [glu_pkg::OFS_W-1:0]       req_offset_y,
   input  logic [glu_pkg::ADV_W-1:0]              req_advance,
   input  logic                                   req_end_of_text,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [glu_pkg::POS_W-1:0]       rsp_dst_x,
   output logic signed [glu_pkg::POS_W-1:0]       rsp_dst_y,
   output logic [glu_pkg::SIZE_W-1:0]             rsp_dst_w,
   output logic [glu_pkg::SIZE_W-1:0]             rsp_dst_h,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_x,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_y,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_w,
   output logic [glu_pkg::ATLAS_W-1:0]            rsp_src_h,
   output logic [glu_pkg::COLOR_W-1:0]            rsp_quad_color,
   output logic                                   rsp_last,
   input  logic                                   csr_wr_en,
   input  logic [glu_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [glu_pkg::CSR_DATA_W-1:0]         csr_wr_data
);

   glu_pkg::dp_cmd_type      dp_cmd;
   glu_pkg::dp_status_type   dp_status;

   // Sequencer.
   glu_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Storage and arithmetic.
   glu_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_atlas_x     (req_atlas_x),
      .req_atlas_y     (req_atlas_y),
      .req_glyph_w     (req_glyph_w),
      .req_glyph_h     (req_glyph_h),
      .req_offset_x    (req_offset_x),
      .req_offset_y    (req_offset_y),
      .req_advance     (req_advance),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dst_x       (rsp_dst_x),
      .rsp_dst_y       (rsp_dst_y),
      .rsp_dst_w       (rsp_dst_w),
      .rsp_dst_h       (rsp_dst_h),
      .rsp_src_x       (rsp_src_x),
      .rsp_src_y       (rsp_src_y),
      .rsp_src_w       (rsp_src_w),
      .rsp_src_h       (rsp_src_h),
      .rsp_quad_color  (rsp_quad_color),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   // The divider is only started when idle, and it runs in the next cycle.
   `GLU_ASSERT_IMPLIES(a_div_start_idle, clock, reset, dp_cmd.div_start, !dp_status.div_busy)
   `GLU_ASSERT_NEXT(a_div_runs, clock, reset, dp_cmd.div_start, dp_status.div_busy)
   // A quad is never loaded over one that has not been taken.
   `GLU_ASSERT_IMPLIES(a_emit_free, clock, reset, dp_cmd.emit, dp_status.rsp_free)
   // No request is taken while a character is still being scaled.
   `GLU_ASSERT_IMPLIES(a_ready_quiet, clock, reset, req_ready, !dp_status.div_busy)

endmodule

// ===== tb/sv/glyph_layout_checker.sv =====
//------------------------------------------------------------------------------
// Glyph layout checker
// Watches the request, result and register ports of the glyph text layout
// unit. It keeps its own glyph table, cursor and register copies, works out
// the quad that each drawn character must produce, and compares every quad
// taken from the unit, field by field, with the oldest one still owed.
//------------------------------------------------------------------------------
module glyph_layout_checker
   import glu_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_func,
   input  logic [CODE_W-1:0]             req_char_code,
   input  logic [ATLAS_W-1:0]            req_atlas_x,
   input  logic [ATLAS_W-1:0]            req_atlas_y,
   input  logic [ATLAS_W-1:0]            req_glyph_w,
   input  logic [ATLAS_W-1:0]            req_glyph_h,
   input  logic signed [OFS_W-1:0]       req_offset_x,
   input  logic signed [OFS_W-1:0]       req_offset_y,
   input  logic [ADV_W-1:0]              req_advance,
   input  logic                          req_end_of_text,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [POS_W-1:0]       rsp_dst_x,
   input  logic signed [POS_W-1:0]       rsp_dst_y,
   input  logic [SIZE_W-1:0]             rsp_dst_w,
   input  logic [SIZE_W-1:0]             rsp_dst_h,
   input  logic [ATLAS_W-1:0]            rsp_src_x,
   input  logic [ATLAS_W-1:0]            rsp_src_y,
   input  logic [ATLAS_W-1:0]            rsp_src_w,
   input  logic [ATLAS_W-1:0]            rsp_src_h,
   input  logic [COLOR_W-1:0]            rsp_quad_color,
   input  logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wr_data,
   output int                            mismatches,
   output int                            outstanding,
   output int                            quads_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // One screen quad as the unit presents it.
   typedef struct packed {
      logic signed [POS_W-1:0] dst_x;
      logic signed [POS_W-1:0] dst_y;
      logic [SIZE_W-1:0]       dst_w;
      logic [SIZE_W-1:0]       dst_h;
      logic [ATLAS_W-1:0]      src_x;
      logic [ATLAS_W-1:0]      src_y;
      logic [ATLAS_W-1:0]      src_w;
      logic [ATLAS_W-1:0]      src_h;
      logic [COLOR_W-1:0]      color;
      logic                    last;
   } quad_type;

   glyph_entry_type         glyph_table [GLYPH_COUNT];
   logic signed [POS_W-1:0] origin_x;
   logic signed [POS_W-1:0] origin_y;
   logic [FONT_W-1:0]       font_size;
   logic [COLOR_W-1:0]      quad_color;
   longint                  cursor_x;
   longint                  cursor_y;
   quad_type                owed_quads [$];
   int                      fail_total = 0;
   int                      checked_total = 0;

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      quads_checked = 0;
   end

   // Glyph metric scaled by font size over line height, truncated toward zero.
   function automatic longint scale_metric(input longint value, input longint line_h);
      longint size;
      size = font_size;
      if (line_h == 0) begin
         return 0;
      end
      return (value * size) / line_h;
   endfunction

   function automatic longint clamp(input longint value, input longint lo, input longint hi);
      if (value < lo) begin
         return lo;
      end
      if (value > hi) begin
         return hi;
      end
      return value;
   endfunction

   // Applies one accepted request to the glyph table and the cursor, and
   // queues the quad that a drawn character owes.
   task automatic lay_out_request(
      input logic                    func,
      input logic [CODE_W-1:0]       code,
      input logic [ATLAS_W-1:0]      atlas_x,
      input logic [ATLAS_W-1:0]      atlas_y,
      input logic [ATLAS_W-1:0]      glyph_w,
      input logic [ATLAS_W-1:0]      glyph_h,
      input logic signed [OFS_W-1:0] offset_x,
      input logic signed [OFS_W-1:0] offset_y,
      input logic [ADV_W-1:0]        advance,
      input logic                    eot
   );
      glyph_entry_type g;
      longint          line_h;
      longint          step;
      quad_type        q;
      if (func == FUNC_WRITE) begin
         g.ax  = atlas_x;
         g.ay  = atlas_y;
         g.w   = glyph_w;
         g.h   = glyph_h;
         g.ox  = offset_x;
         g.oy  = offset_y;
         g.adv = advance;
         glyph_table[code] = g;
      end else begin
         if (code == CH_NEWLINE) begin
            cursor_x = 0;
            cursor_y = clamp(cursor_y + font_size, 0, CURSOR_MAX);
         end else begin
            // Line height is twice the underscore advance.
            line_h = 2 * glyph_table[CH_UNDERSCORE].adv;
            g = glyph_table[code];
            q.dst_x = clamp(scale_metric($signed(g.ox), line_h) + cursor_x + origin_x,
                            DST_MIN, DST_MAX);
            q.dst_y = clamp(scale_metric($signed(g.oy), line_h) + cursor_y + origin_y,
                            DST_MIN, DST_MAX);
            q.dst_w = clamp(scale_metric(g.w, line_h), 0, SIZE_MAX);
            q.dst_h = clamp(scale_metric(g.h, line_h), 0, SIZE_MAX);
            q.src_x = g.ax;
            q.src_y = g.ay;
            q.src_w = g.w;
            q.src_h = g.h;
            q.color = quad_color;
            q.last  = eot;
            owed_quads = {owed_quads, q};
            // A space steps by the underscore advance, not its own.
            step = scale_metric(code == CH_SPACE ? glyph_table[CH_UNDERSCORE].adv : g.adv,
                                line_h);
            cursor_x = clamp(cursor_x + step, 0, CURSOR_MAX);
         end
         if (eot) begin
            cursor_x = 0;
            cursor_y = 0;
         end
      end
   endtask

   task automatic check_field(input string field, input logic signed [63:0] want_v,
                              input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         fail_total++;
         if (fail_total <= REPORT_LIMIT) begin
            $display("quad %0d: %s expected %0d, got %0d", checked_total, field, want_v,
                     got_v);
         end
      end
   endtask

   // Sample all ports on the clock edge, in the order: result, request, register.
   always @(posedge clock) begin : monitor
      quad_type got;
      quad_type want;
      if (reset) begin
         foreach (glyph_table[i]) begin
            glyph_table[i] = '0;
         end
         origin_x   = '0;
         origin_y   = '0;
         font_size  = FONT_SIZE_RESET;
         quad_color = '0;
         cursor_x   = 0;
         cursor_y   = 0;
         owed_quads.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.dst_x = rsp_dst_x;
            got.dst_y = rsp_dst_y;
            got.dst_w = rsp_dst_w;
            got.dst_h = rsp_dst_h;
            got.src_x = rsp_src_x;
            got.src_y = rsp_src_y;
            got.src_w = rsp_src_w;
            got.src_h = rsp_src_h;
            got.color = rsp_quad_color;
            got.last  = rsp_last;
            if (owed_quads.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT) begin
                  $display("unrequested quad: dst %0d,%0d size %0dx%0d last %0b",
                           got.dst_x, got.dst_y, got.dst_w, got.dst_h, got.last);
               end
            end else begin
               want = owed_quads.pop_front();
               check_field("dst_x", want.dst_x, got.dst_x);
               check_field("dst_y", want.dst_y, got.dst_y);
               check_field("dst_w", want.dst_w, got.dst_w);
               check_field("dst_h", want.dst_h, got.dst_h);
               check_field("src_x", want.src_x, got.src_x);
               check_field("src_y", want.src_y, got.src_y);
               check_field("src_w", want.src_w, got.src_w);
               check_field("src_h", want.src_h, got.src_h);
               check_field("quad_color", want.color, got.color);
               check_field("last", want.last, got.last);
               checked_total++;
            end
         end
         if (req_valid && req_ready) begin
            lay_out_request(req_func, req_char_code, req_atlas_x, req_atlas_y, req_glyph_w,
                            req_glyph_h, req_offset_x, req_offset_y, req_advance,
                            req_end_of_text);
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POS_X: begin
                  origin_x = csr_wr_data[POS_W-1:0];
               end
               CSR_POS_Y: begin
                  origin_y = csr_wr_data[POS_W-1:0];
               end
               CSR_FONT_SIZE: begin
                  font_size = csr_wr_data[FONT_W-1:0];
               end
               CSR_COLOR: begin
                  quad_color = csr_wr_data[COLOR_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      mismatches    <= fail_total;
      outstanding   <= owed_quads.size();
      quads_checked <= checked_total;
   end

endmodule

// ===== tb/sv/tb_glyph_text_layout_unit.sv =====
//------------------------------------------------------------------------------
// Glyph text layout unit testbench
// Drives glyph writes and character strings into the unit under random
// back-pressure on both channels, changes the registers between phases while
// the unit is idle, and leaves all quad checking to the layout checker.
//------------------------------------------------------------------------------
module tb_glyph_text_layout_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import glu_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int PHASE_ITEMS   = 260;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 800_000;
   localparam int MAX_IDLE      = 18;
   localparam int CSR_SLOTS     = 5;

   localparam logic [CODE_W-1:0] CH_PRINT_FIRST = 7'd33;
   localparam logic [CODE_W-1:0] CH_PRINT_LAST  = 7'd126;
   localparam logic [CODE_W-1:0] CH_LETTER_A    = 7'd65;
   localparam logic [CODE_W-1:0] CH_FIRST       = 7'd0;
   localparam logic [CODE_W-1:0] CH_LAST        = 7'd127;

   // One request as driven onto the input channel.
   typedef struct {
      logic                    func;
      logic [CODE_W-1:0]       code;
      logic [ATLAS_W-1:0]      ax;
      logic [ATLAS_W-1:0]      ay;
      logic [ATLAS_W-1:0]      w;
      logic [ATLAS_W-1:0]      h;
      logic signed [OFS_W-1:0] ox;
      logic signed [OFS_W-1:0] oy;
      logic [ADV_W-1:0]        adv;
      logic                    eot;
   } request_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_func;
   logic [CODE_W-1:0]       req_char_code;
   logic [ATLAS_W-1:0]      req_atlas_x;
   logic [ATLAS_W-1:0]      req_atlas_y;
   logic [ATLAS_W-1:0]      req_glyph_w;
   logic [ATLAS_W-1:0]      req_glyph_h;
   logic signed [OFS_W-1:0] req_offset_x;
   logic signed [OFS_W-1:0] req_offset_y;
   logic [ADV_W-1:0]        req_advance;
   logic                    req_end_of_text;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [POS_W-1:0] rsp_dst_x;
   logic signed [POS_W-1:0] rsp_dst_y;
   logic [SIZE_W-1:0]       rsp_dst_w;
   logic [SIZE_W-1:0]       rsp_dst_h;
   logic [ATLAS_W-1:0]      rsp_src_x;
   logic [ATLAS_W-1:0]      rsp_src_y;
   logic [ATLAS_W-1:0]      rsp_src_w;
   logic [ATLAS_W-1:0]      rsp_src_h;
   logic [COLOR_W-1:0]      rsp_quad_color;
   logic                    rsp_last;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wr_data;

   int mismatches;
   int outstanding;
   int quads_checked;

   // Idle odds per phase (zero means no idling) and the quiet tail flag.
   int gap_odds   = 4;
   int stall_odds = 4;
   bit calm       = 1'b0;

   int                items_sent    = 0;
   int                glyph_writes  = 0;
   int                chars_sent    = 0;
   int                newlines_sent = 0;
   int                settings_done = 0;
   logic [FONT_W-1:0] cur_font      = FONT_SIZE_RESET;

   glyph_text_layout_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_atlas_x     (req_atlas_x),
      .req_atlas_y     (req_atlas_y),
      .req_glyph_w     (req_glyph_w),
      .req_glyph_h     (req_glyph_h),
      .req_offset_x    (req_offset_x),
      .req_offset_y    (req_offset_y),
      .req_advance     (req_advance),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dst_x       (rsp_dst_x),
      .rsp_dst_y       (rsp_dst_y),
      .rsp_dst_w       (rsp_dst_w),
      .rsp_dst_h       (rsp_dst_h),
      .rsp_src_x       (rsp_src_x),
      .rsp_src_y       (rsp_src_y),
      .rsp_src_w       (rsp_src_w),
      .rsp_src_h       (rsp_src_h),
      .rsp_quad_color  (rsp_quad_color),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   glyph_layout_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_atlas_x     (req_atlas_x),
      .req_atlas_y     (req_atlas_y),
      .req_glyph_w     (req_glyph_w),
      .req_glyph_h     (req_glyph_h),
      .req_offset_x    (req_offset_x),
      .req_offset_y    (req_offset_y),
      .req_advance     (req_advance),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dst_x       (rsp_dst_x),
      .rsp_dst_y       (rsp_dst_y),
      .rsp_dst_w       (rsp_dst_w),
      .rsp_dst_h       (rsp_dst_h),
      .rsp_src_x       (rsp_src_x),
      .rsp_src_y       (rsp_src_y),
      .rsp_src_w       (rsp_src_w),
      .rsp_src_h       (rsp_src_h),
      .rsp_quad_color  (rsp_quad_color),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .quads_checked   (quads_checked)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(CYCLE_LIMIT * CLK_PERIOD);
      $display("Timed out with %0d quads still owed.", outstanding);
      $display("glyph_text_layout_unit: mismatch");
      $finish;
   end

   // Result side: stalls come in bursts, and not at all in the quiet tail.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Every field random; callers then pin down what matters.
   function automatic request_type random_request();
      request_type r;
      r.func = $urandom_range(0, 1);
      r.code = $urandom_range(0, GLYPH_COUNT - 1);
      r.ax   = $urandom;
      r.ay   = $urandom;
      r.w    = $urandom;
      r.h    = $urandom;
      r.ox   = $urandom;
      r.oy   = $urandom;
      r.adv  = $urandom;
      r.eot  = $urandom_range(0, 1);
      return r;
   endfunction

   function automatic request_type render_request(input logic [CODE_W-1:0] code,
                                                  input logic eot);
      request_type r;
      r      = random_request();
      r.func = FUNC_RENDER;
      r.code = code;
      r.eot  = eot;
      return r;
   endfunction

   function automatic request_type glyph_request(
      input logic [CODE_W-1:0] code,
      input logic [ATLAS_W-1:0] ax, input logic [ATLAS_W-1:0] ay,
      input logic [ATLAS_W-1:0] w, input logic [ATLAS_W-1:0] h,
      input logic signed [OFS_W-1:0] ox, input logic signed [OFS_W-1:0] oy,
      input logic [ADV_W-1:0] adv
   );
      request_type r;
      r      = random_request();
      r.func = FUNC_WRITE;
      r.code = code;
      r.ax   = ax;
      r.ay   = ay;
      r.w    = w;
      r.h    = h;
      r.ox   = ox;
      r.oy   = oy;
      r.adv  = adv;
      return r;
   endfunction

   // A glyph with the modest metrics of an ordinary font.
   function automatic request_type font_glyph(input logic [CODE_W-1:0] code);
      request_type r;
      r      = random_request();
      r.func = FUNC_WRITE;
      r.code = code;
      r.w    = $urandom_range(0, 64);
      r.h    = $urandom_range(0, 64);
      r.ox   = $urandom_range(0, 32) - 16;
      r.oy   = $urandom_range(0, 32) - 16;
      r.adv  = (code == CH_UNDERSCORE) ? $urandom_range(4, 20) : $urandom_range(1, 40);
      return r;
   endfunction

   // A glyph with full-range fields; an underscore often gets a tiny or zero
   // advance so the line height swings to its extremes.
   function automatic request_type wild_glyph(input logic [CODE_W-1:0] code);
      request_type r;
      r      = random_request();
      r.func = FUNC_WRITE;
      r.code = code;
      if (code == CH_UNDERSCORE) begin
         case ($urandom_range(0, 5))
            0: r.adv = '0;
            1, 2: r.adv = $urandom_range(1, 8);
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   function automatic logic [CODE_W-1:0] pick_char();
      case ($urandom_range(0, 9))
         0: return CH_SPACE;
         1: return CH_NEWLINE;
         2: return CH_UNDERSCORE;
         3: return $urandom_range(0, GLYPH_COUNT - 1);
         default: return $urandom_range(CH_PRINT_FIRST, CH_PRINT_LAST);
      endcase
   endfunction

   task automatic drive_payload(input request_type r);
      req_func        <= r.func;
      req_char_code   <= r.code;
      req_atlas_x     <= r.ax;
      req_atlas_y     <= r.ay;
      req_glyph_w     <= r.w;
      req_glyph_h     <= r.h;
      req_offset_x    <= r.ox;
      req_offset_y    <= r.oy;
      req_advance     <= r.adv;
      req_end_of_text <= r.eot;
   endtask

   // Offers one request, maybe after an idle burst, and waits for acceptance.
   // Valid stays high afterwards so back-to-back requests need no extra edge.
   task automatic send_request(input request_type r);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_IDLE)) @(posedge clock);
      end
      req_valid <= 1'b1;
      drive_payload(r);
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (r.func == FUNC_WRITE) begin
         glyph_writes++;
      end else if (r.code == CH_NEWLINE) begin
         newlines_sent++;
      end else begin
         chars_sent++;
      end
   endtask

   // Holds off requests until every owed quad is out, then lets the unit
   // finish any newline or glyph write still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers plus one unused index, on an idle unit.
   task automatic apply_settings(input logic signed [POS_W-1:0] px,
                                 input logic signed [POS_W-1:0] py,
                                 input logic [FONT_W-1:0] fs,
                                 input logic [COLOR_W-1:0] col);
      logic [CSR_IDX_W-1:0]  idx [CSR_SLOTS];
      logic [CSR_DATA_W-1:0] val [CSR_SLOTS];
      settle();
      idx[0] = CSR_POS_X;
      idx[1] = CSR_POS_Y;
      idx[2] = CSR_FONT_SIZE;
      idx[3] = CSR_COLOR;
      idx[4] = $urandom_range(CSR_COLOR + 1, (1 << CSR_IDX_W) - 1);
      // Upper data bits above a register's width are noise.
      val[0] = $urandom;
      val[0][POS_W-1:0] = px;
      val[1] = $urandom;
      val[1][POS_W-1:0] = py;
      val[2] = $urandom;
      val[2][FONT_W-1:0] = fs;
      val[3] = col;
      val[4] = $urandom;
      for (int i = 0; i < CSR_SLOTS; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[i];
         csr_wr_data <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cur_font = fs;
      settings_done++;
   endtask

   initial begin : stimulus
      request_type       r;
      int                phase;
      int                phase_start;
      int                stop_mark;
      int                calm_mark;
      int                len;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      drive_payload('{default: '0});
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: an empty table gives a zero line height.
      send_request(render_request(CH_LETTER_A, 1'b0));
      send_request(glyph_request(CH_UNDERSCORE, '1, '0, '1, '0, -512, 511, 8));
      send_request(glyph_request(CH_LETTER_A, '1, '1, '1, '1, 511, -512, '1));
      send_request(glyph_request(CH_LAST, '0, '0, '0, '0, 0, 0, '0));
      send_request(glyph_request(CH_SPACE, 1, 2, 3, 4, 5, 6, '1));
      send_request(render_request(CH_LETTER_A, 1'b0));
      send_request(render_request(CH_SPACE, 1'b0));
      send_request(render_request(CH_UNDERSCORE, 1'b0));
      send_request(render_request(CH_NEWLINE, 1'b0));
      send_request(render_request(CH_LAST, 1'b0));
      send_request(render_request(CH_LETTER_A, 1'b1));
      send_request(render_request(CH_NEWLINE, 1'b0));
      send_request(render_request(CH_NEWLINE, 1'b1));
      send_request(render_request(CH_FIRST, 1'b1));

      // Largest x origin, smallest y origin and largest font: positions, sizes and the cursor saturate.
      apply_settings(16'sh7FFF, 16'sh8000, 8'd255, '1);
      repeat (3) send_request(render_request(CH_LETTER_A, 1'b0));
      send_request(render_request(CH_LETTER_A, 1'b1));

      // Smallest x origin, largest y origin and a zero font size: every scaled value is zero.
      apply_settings(16'sh8000, 16'sh7FFF, 8'd0, '0);
      send_request(render_request(CH_LETTER_A, 1'b0));
      send_request(render_request(CH_NEWLINE, 1'b0));
      send_request(render_request(CH_UNDERSCORE, 1'b1));

      // Random part: load a plain font, then phases of strings and rewrites.
      stop_mark = items_sent + RANDOM_ITEMS;
      calm_mark = stop_mark - RANDOM_ITEMS / 10;
      for (int c = 0; c < GLYPH_COUNT; c++) begin
         send_request(font_glyph(c));
      end
      phase = 0;
      while (items_sent < stop_mark) begin
         if (items_sent >= calm_mark) begin
            calm = 1'b1;
         end
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 3;
            default: gap_odds = 12;
         endcase
         case ($urandom_range(0, 2))
            0: stall_odds = 0;
            1: stall_odds = 3;
            default: stall_odds = 12;
         endcase
         if ($urandom_range(0, 1) == 1) begin
            px = $urandom;
            py = $urandom;
         end else begin
            px = $urandom_range(0, 600) - 300;
            py = $urandom_range(0, 600) - 300;
         end
         case (phase % 6)
            1: apply_settings(16'sh7FFF, 16'sh7FFF, 8'd255, '1);
            3: apply_settings(16'sh8000, 16'sh8000, 8'd1, '0);
            5: apply_settings(px, py, 8'd0, $urandom);
            default: apply_settings(px, py, $urandom_range(1, 255), $urandom);
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent < stop_mark) begin
            case ($urandom_range(0, 99)) inside
               [0:14]: begin
                  // Rewrite a few glyphs, the underscore among them at times.
                  repeat ($urandom_range(1, 6)) begin
                     r.code = ($urandom_range(0, 3) == 0) ? CH_UNDERSCORE
                                                          : $urandom_range(0, GLYPH_COUNT - 1);
                     send_request($urandom_range(0, 1) ? font_glyph(r.code)
                                                       : wild_glyph(r.code));
                  end
               end
               [15:79]: begin
                  // A whole string ending in its end-of-text character.
                  len = $urandom_range(1, 16);
                  for (int i = 0; i < len; i++) begin
                     send_request(render_request(pick_char(), i == len - 1));
                  end
               end
               [80:87]: begin
                  // A string cut short, with no end-of-text.
                  repeat ($urandom_range(1, 8)) send_request(render_request(pick_char(), 1'b0));
               end
               [88:91]: begin
                  // With a font size of 170 or more, enough newlines to pin the cursor at the bottom.
                  if (cur_font >= 170) begin
                     repeat (32767 / cur_font + 3) begin
                        send_request(render_request(CH_NEWLINE, 1'b0));
                     end
                  end
                  send_request(render_request(pick_char(), 1'b1));
               end
               default: begin
                  send_request(random_request());
               end
            endcase
            if (items_sent >= calm_mark) begin
               calm = 1'b1;
            end
         end
         phase++;
      end

      settle();
      $display("Sent %0d glyph writes, %0d characters and %0d newlines over %0d settings.",
               glyph_writes, chars_sent, newlines_sent, settings_done);
      $display("Compared %0d quads; %0d field mismatches.", quads_checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("glyph_text_layout_unit: match");
      end else begin
         $display("glyph_text_layout_unit: mismatch");
      end
      $finish;
   end

endmodule
